// ===== hdl/mmw_pkg.sv =====
`timescale 1ns / 1ps

package mmw_pkg;

  localparam int unsigned MAX_ROWS    = 16;
  localparam int unsigned MAX_INNER   = 16;
  localparam int unsigned MAX_COLS    = 4096;
  localparam int unsigned STORE_DEPTH = MAX_ROWS * MAX_INNER;

  localparam int unsigned DATA_W     = 16;
  localparam int unsigned DIM_W      = 5;
  localparam int unsigned COLS_W     = 13;
  localparam int unsigned ROW_W      = $clog2(MAX_ROWS);
  localparam int unsigned COL_W      = $clog2(MAX_COLS);
  localparam int unsigned ADDR_W     = $clog2(STORE_DEPTH);
  localparam int unsigned SIZE_W     = ADDR_W + 1;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;

  localparam logic OP_LOAD_A = 1'b0;
  localparam logic OP_LOAD_B = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_EMIT
  } mmw_state_e;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [ROW_W-1:0]  rd_row;
    logic              acc_clear;
    logic [ROW_W-1:0]  acc_sel;
  } mmw_ctrl_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [COLS_W-1:0] clamp_cols(input logic [COLS_W-1:0] v);
    logic [COLS_W-1:0] r;
    if (v == '0) begin
      r = COLS_W'(1);
    end else if (v > COLS_W'(MAX_COLS)) begin
      r = COLS_W'(MAX_COLS);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== hdl/mmw_mac.sv =====
`timescale 1ns / 1ps

module mmw_mac (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  mmw_pkg::mmw_ctrl_t             ctrl_i,
  input  logic [mmw_pkg::DATA_W-1:0]     wr_data_i,
  input  logic [mmw_pkg::DATA_W-1:0]     mult_i,
  output logic [mmw_pkg::DATA_W-1:0]     acc_o,
  output logic                           pipe_busy_o
);

  logic [mmw_pkg::DATA_W-1:0]   mem [mmw_pkg::STORE_DEPTH];
  logic [mmw_pkg::DATA_W-1:0]   rdata_q;
  logic [mmw_pkg::DATA_W-1:0]   prod_q;
  logic [2*mmw_pkg::DATA_W-1:0] prod_full;
  logic                         s1_v_q;
  logic                         s2_v_q;
  logic [mmw_pkg::ROW_W-1:0]    s1_row_q;
  logic [mmw_pkg::ROW_W-1:0]    s2_row_q;
  logic [mmw_pkg::DATA_W-1:0]   acc_q [mmw_pkg::MAX_ROWS];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem[ctrl_i.wr_addr] <= wr_data_i;
    end
    if (ctrl_i.rd_en) begin
      rdata_q <= mem[ctrl_i.rd_addr];
    end
  end

  assign prod_full = rdata_q * mult_i;

  always_ff @(posedge clk_i) begin
    s1_row_q <= ctrl_i.rd_row;
    s2_row_q <= s1_row_q;
    prod_q   <= prod_full[mmw_pkg::DATA_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= ctrl_i.rd_en;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < mmw_pkg::MAX_ROWS; i++) begin
        acc_q[i] <= '0;
      end
    end else if (ctrl_i.acc_clear) begin
      for (int i = 0; i < mmw_pkg::MAX_ROWS; i++) begin
        acc_q[i] <= '0;
      end
    end else if (s2_v_q) begin
      acc_q[s2_row_q] <= acc_q[s2_row_q] + prod_q;
    end
  end

  assign acc_o       = acc_q[ctrl_i.acc_sel];
  assign pipe_busy_o = s1_v_q | s2_v_q;

endmodule

// ===== hdl/uint16_matrix_multiply_wrap_top.sv =====
`timescale 1ns / 1ps

// Unsigned 16-bit matrix multiply modulo 65536. An A item (operation 0) is written to the
// store and busy stays low. A B item (operation 1) runs through one shared multiply-
// accumulate that handles one product row per cycle in a three-stage store read,
// multiply and accumulate pipeline, and busy stays high until that pipeline drains. On the
// last B item of a column the block then emits that product column, one row per cycle,
// with busy held high. Each result is shown for exactly one cycle under out_valid_o
// and cannot be held off, so the receiver must take every row as it comes.

module uint16_matrix_multiply_wrap_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic                               operation_i,
  input  logic [mmw_pkg::DATA_W-1:0]         value_i,
  input  logic                               cfg_we_i,
  input  logic [mmw_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [mmw_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output logic                               out_valid_o,
  output logic [mmw_pkg::DATA_W-1:0]         product_o,
  output logic [mmw_pkg::ROW_W-1:0]          row_index_o,
  output logic [mmw_pkg::COL_W-1:0]          column_index_o,
  output logic                               column_last_o,
  output logic                               matrix_done_o
);

  mmw_pkg::mmw_state_e state_q, state_d;
  mmw_pkg::mmw_ctrl_t  ctrl;

  logic [mmw_pkg::DIM_W-1:0]  rows_q, inner_q;
  logic [mmw_pkg::COLS_W-1:0] cols_q;
  logic [mmw_pkg::DIM_W-1:0]  nr, ni;
  logic [mmw_pkg::COLS_W-1:0] nc;
  logic [mmw_pkg::SIZE_W-1:0] size;
  logic [mmw_pkg::SIZE_W-1:0] a_ptr_inc;
  logic [mmw_pkg::ADDR_W-1:0] a_ptr_q, a_ptr_eff, a_ptr_nxt;
  logic [mmw_pkg::ROW_W-1:0]  brc_q, brc_eff;
  logic [mmw_pkg::COL_W-1:0]  bcc_q, bcc_eff;
  logic [mmw_pkg::SIZE_W-1:0] base_full;
  logic                       row_last, col_last;
  logic                       accept, accept_a, accept_b;

  logic [mmw_pkg::DATA_W-1:0] v_q;
  logic [mmw_pkg::DIM_W-1:0]  nr_q;
  logic [mmw_pkg::ADDR_W-1:0] base_q;
  logic [mmw_pkg::DIM_W-1:0]  cnt_q, cnt_inc;
  logic                       row_last_q;
  logic [mmw_pkg::COL_W-1:0]  col_q;
  logic                       last_col_q;
  logic                       emit_last;

  logic [mmw_pkg::DATA_W-1:0] acc;
  logic                       pipe_busy;

  logic                       out_valid_q;
  logic [mmw_pkg::DATA_W-1:0] product_q;
  logic [mmw_pkg::ROW_W-1:0]  row_q;
  logic [mmw_pkg::COL_W-1:0]  out_col_q;
  logic                       column_last_q;
  logic                       matrix_done_q;

  assign nr   = mmw_pkg::clamp_dim(rows_q, mmw_pkg::DIM_W'(mmw_pkg::MAX_ROWS));
  assign ni   = mmw_pkg::clamp_dim(inner_q, mmw_pkg::DIM_W'(mmw_pkg::MAX_INNER));
  assign nc   = mmw_pkg::clamp_cols(cols_q);
  assign size = mmw_pkg::SIZE_W'(nr) * mmw_pkg::SIZE_W'(ni);

  assign a_ptr_eff = ({1'b0, a_ptr_q} >= size) ? '0 : a_ptr_q;
  assign a_ptr_inc = {1'b0, a_ptr_eff} + mmw_pkg::SIZE_W'(1);
  assign a_ptr_nxt = (a_ptr_inc >= size) ? '0 : a_ptr_inc[mmw_pkg::ADDR_W-1:0];

  assign brc_eff   = (mmw_pkg::DIM_W'(brc_q) >= ni) ? '0 : brc_q;
  assign bcc_eff   = (mmw_pkg::COLS_W'(bcc_q) >= nc) ? '0 : bcc_q;
  assign row_last  = (mmw_pkg::DIM_W'(brc_eff) + mmw_pkg::DIM_W'(1)) == ni;
  assign col_last  = (mmw_pkg::COLS_W'(bcc_eff) + mmw_pkg::COLS_W'(1)) >= nc;
  assign base_full = mmw_pkg::SIZE_W'(brc_eff) * mmw_pkg::SIZE_W'(nr);

  assign accept   = start_i && (state_q == mmw_pkg::ST_IDLE);
  assign accept_a = accept && (operation_i == mmw_pkg::OP_LOAD_A);
  assign accept_b = accept && (operation_i == mmw_pkg::OP_LOAD_B);

  assign cnt_inc   = cnt_q + mmw_pkg::DIM_W'(1);
  assign emit_last = (cnt_inc == nr_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      mmw_pkg::ST_IDLE: begin
        if (accept_b) begin
          state_d = mmw_pkg::ST_MAC;
        end
      end
      mmw_pkg::ST_MAC: begin
        if ((cnt_q == nr_q) && !pipe_busy) begin
          state_d = row_last_q ? mmw_pkg::ST_EMIT : mmw_pkg::ST_IDLE;
        end
      end
      mmw_pkg::ST_EMIT: begin
        if (emit_last) begin
          state_d = mmw_pkg::ST_IDLE;
        end
      end
      default: state_d = mmw_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy_o         = 1'b1;
    ctrl.wr_en     = accept_a;
    ctrl.wr_addr   = a_ptr_eff;
    ctrl.rd_en     = 1'b0;
    ctrl.rd_addr   = base_q + mmw_pkg::ADDR_W'(cnt_q[mmw_pkg::ROW_W-1:0]);
    ctrl.rd_row    = cnt_q[mmw_pkg::ROW_W-1:0];
    ctrl.acc_clear = accept_a;
    ctrl.acc_sel   = cnt_q[mmw_pkg::ROW_W-1:0];
    case (state_q)
      mmw_pkg::ST_IDLE: begin
        busy_o = 1'b0;
      end
      mmw_pkg::ST_MAC: begin
        ctrl.rd_en = (cnt_q != nr_q);
      end
      mmw_pkg::ST_EMIT: begin
        ctrl.acc_clear = emit_last;
      end
      default: begin
        busy_o = 1'b1;
      end
    endcase
  end

  mmw_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .wr_data_i   (value_i),
    .mult_i      (v_q),
    .acc_o       (acc),
    .pipe_busy_o (pipe_busy)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= mmw_pkg::DIM_W'(1);
      inner_q <= mmw_pkg::DIM_W'(1);
      cols_q  <= mmw_pkg::COLS_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mmw_pkg::REG_ROWS:  rows_q  <= cfg_data_i[mmw_pkg::DIM_W-1:0];
        mmw_pkg::REG_INNER: inner_q <= cfg_data_i[mmw_pkg::DIM_W-1:0];
        mmw_pkg::REG_COLS:  cols_q  <= cfg_data_i[mmw_pkg::COLS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mmw_pkg::ST_IDLE;
      a_ptr_q     <= '0;
      brc_q       <= '0;
      bcc_q       <= '0;
      cnt_q       <= '0;
      nr_q        <= mmw_pkg::DIM_W'(1);
      row_last_q  <= 1'b0;
      last_col_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= (state_q == mmw_pkg::ST_EMIT);
      if (accept_a) begin
        a_ptr_q <= a_ptr_nxt;
        brc_q   <= '0;
        bcc_q   <= '0;
      end else if (accept_b) begin
        nr_q       <= nr;
        row_last_q <= row_last;
        last_col_q <= col_last;
        cnt_q      <= '0;
        if (row_last) begin
          brc_q <= '0;
          bcc_q <= col_last ? '0 : bcc_eff + mmw_pkg::COL_W'(1);
        end else begin
          brc_q <= brc_eff + mmw_pkg::ROW_W'(1);
          bcc_q <= bcc_eff;
        end
      end else if (state_q == mmw_pkg::ST_MAC) begin
        if (cnt_q != nr_q) begin
          cnt_q <= cnt_inc;
        end else if (!pipe_busy) begin
          cnt_q <= '0;
        end
      end else if (state_q == mmw_pkg::ST_EMIT) begin
        cnt_q <= cnt_inc;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_b) begin
      v_q    <= value_i;
      base_q <= base_full[mmw_pkg::ADDR_W-1:0];
      col_q  <= bcc_eff;
    end
    product_q     <= acc;
    row_q         <= cnt_q[mmw_pkg::ROW_W-1:0];
    out_col_q     <= col_q;
    column_last_q <= emit_last;
    matrix_done_q <= emit_last && last_col_q;
  end

  assign out_valid_o    = out_valid_q;
  assign product_o      = product_q;
  assign row_index_o    = row_q;
  assign column_index_o = out_col_q;
  assign column_last_o  = column_last_q;
  assign matrix_done_o  = matrix_done_q;

endmodule

// ===== hdl/mmw_checker.sv =====
`timescale 1ns / 1ps

module mmw_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          busy_o,
  input logic                          out_valid_o,
  input logic [mmw_pkg::ROW_W-1:0]     row_index_o,
  input logic                          column_last_o,
  input logic                          matrix_done_o
);

  // A finished product is always the end of a column.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && matrix_done_o) |-> column_last_o)
    else $error("matrix_done without column_last");

  // The rows of a column come out in consecutive cycles.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !column_last_o) |=> out_valid_o)
    else $error("gap inside an emitted column");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !column_last_o) |=>
      (row_index_o == $past(row_index_o) + mmw_pkg::ROW_W'(1)))
    else $error("row index does not advance by one");

  // A column starts at row zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (row_index_o != '0)) |-> $past(out_valid_o))
    else $error("column does not start at row zero");

  // The block stays busy while more rows of a column are to come.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !column_last_o) |-> busy_o)
    else $error("block idle in the middle of a column");

endmodule

bind uint16_matrix_multiply_wrap_top mmw_checker u_mmw_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .busy_o        (busy_o),
  .out_valid_o   (out_valid_o),
  .row_index_o   (row_index_o),
  .column_last_o (column_last_o),
  .matrix_done_o (matrix_done_o)
);

// ===== tb/sv/mmw_product_checker.sv =====
`timescale 1ns / 1ps

module mmw_product_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic                           busy_i,
  input  logic                           operation_i,
  input  logic [mmw_pkg::DATA_W-1:0]     value_i,
  input  logic                           cfg_we_i,
  input  logic [mmw_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mmw_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           out_valid_i,
  input  logic [mmw_pkg::DATA_W-1:0]     product_i,
  input  logic [mmw_pkg::ROW_W-1:0]      row_index_i,
  input  logic [mmw_pkg::COL_W-1:0]      column_index_i,
  input  logic                           column_last_i,
  input  logic                           matrix_done_i,
  output int                             mismatch_count_o,
  output int                             pending_o
);
  import mmw_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0] product;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  column;
    logic              last;
    logic              done;
  } product_entry_t;

  product_entry_t    expected_products [$];
  logic [DATA_W-1:0] a_matrix [STORE_DEPTH];
  logic [DATA_W-1:0] row_sums [MAX_ROWS];
  logic [DIM_W-1:0]  rows_q;
  logic [DIM_W-1:0]  inner_q;
  logic [COLS_W-1:0] cols_q;
  int unsigned       load_ptr;
  int unsigned       b_row;
  int unsigned       b_col;
  int                errors = 0;

  function automatic int unsigned clamp_count(input int unsigned v, input int unsigned maxv);
    int unsigned r;
    if (v == 0) begin
      r = 1;
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

  task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
    $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
    errors++;
  endtask

  task automatic clear_sums();
    foreach (row_sums[k]) row_sums[k] = '0;
  endtask

  task automatic check_result();
    product_entry_t want;
    if (expected_products.size() == 0) begin
      report("unexpected result", 32'h0, {16'h0, product_i});
    end else begin
      want = expected_products.pop_front();
      if (product_i !== want.product) report("product", want.product, product_i);
      if (row_index_i !== want.row) report("row_index", want.row, row_index_i);
      if (column_index_i !== want.column) report("column_index", want.column, column_index_i);
      if (column_last_i !== want.last) report("column_last", want.last, column_last_i);
      if (matrix_done_i !== want.done) report("matrix_done", want.done, matrix_done_i);
    end
  endtask

  // An accepted B item that closes a column queues one result per product row.
  task automatic compute_product_column(input logic op, input logic [DATA_W-1:0] val);
    int unsigned         nr;
    int unsigned         ni;
    int unsigned         nc;
    int unsigned         span;
    logic [2*DATA_W-1:0] mult;
    bit                  last_col;
    product_entry_t      res;
    nr   = clamp_count(rows_q, MAX_ROWS);
    ni   = clamp_count(inner_q, MAX_INNER);
    nc   = clamp_count(cols_q, MAX_COLS);
    span = nr * ni;
    if (op == OP_LOAD_A) begin
      if (load_ptr >= span) load_ptr = 0;
      a_matrix[load_ptr] = val;
      load_ptr++;
      if (load_ptr >= span) load_ptr = 0;
      clear_sums();
      b_row = 0;
      b_col = 0;
    end else begin
      if (b_row >= ni) b_row = 0;
      if (b_col >= nc) b_col = 0;
      for (int unsigned j = 0; j < nr; j++) begin
        mult        = a_matrix[j + b_row * nr] * val;
        row_sums[j] = row_sums[j] + mult[DATA_W-1:0];
      end
      b_row++;
      if (b_row >= ni) begin
        last_col = (b_col + 1 >= nc);
        for (int unsigned j = 0; j < nr; j++) begin
          res.product = row_sums[j];
          res.row     = ROW_W'(j);
          res.column  = COL_W'(b_col);
          res.last    = (j + 1 == nr);
          res.done    = res.last && last_col;
          expected_products.push_back(res);
        end
        clear_sums();
        b_row = 0;
        b_col = last_col ? 0 : b_col + 1;
      end
    end
  endtask

  task automatic write_config(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_ROWS: begin
        rows_q = data[DIM_W-1:0];
      end
      REG_INNER: begin
        inner_q = data[DIM_W-1:0];
      end
      REG_COLS: begin
        cols_q = data[COLS_W-1:0];
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q   = DIM_W'(1);
      inner_q  = DIM_W'(1);
      cols_q   = COLS_W'(1);
      load_ptr = 0;
      b_row    = 0;
      b_col    = 0;
      foreach (a_matrix[k]) a_matrix[k] = '0;
      clear_sums();
      expected_products.delete();
    end else begin
      if (out_valid_i) check_result();
      if (start_i && !busy_i) compute_product_column(operation_i, value_i);
      if (cfg_we_i) write_config(cfg_idx_i, cfg_data_i);
    end
    pending_o        <= expected_products.size();
    mismatch_count_o <= errors;
  end

endmodule

// ===== tb/sv/tb_uint16_matrix_multiply_wrap_top.sv =====
`timescale 1ns / 1ps

module tb_uint16_matrix_multiply_wrap_top;
  import mmw_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  start_i     = 1'b0;
  logic                  operation_i = OP_LOAD_A;
  logic [DATA_W-1:0]     value_i     = '0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = REG_ROWS;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  busy_o;
  logic                  out_valid_o;
  logic [DATA_W-1:0]     product_o;
  logic [ROW_W-1:0]      row_index_o;
  logic [COL_W-1:0]      column_index_o;
  logic                  column_last_o;
  logic                  matrix_done_o;
  int                    mismatch_count;
  int                    pending_count;

  logic [DIM_W-1:0]      rows_raw  = DIM_W'(1);
  logic [DIM_W-1:0]      inner_raw = DIM_W'(1);
  int unsigned           load_ptr  = 0;
  bit                    a_written [STORE_DEPTH];
  bit                    idling_on = 1'b1;

  uint16_matrix_multiply_wrap_top u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .operation_i    (operation_i),
    .value_i        (value_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .out_valid_o    (out_valid_o),
    .product_o      (product_o),
    .row_index_o    (row_index_o),
    .column_index_o (column_index_o),
    .column_last_o  (column_last_o),
    .matrix_done_o  (matrix_done_o)
  );

  mmw_product_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_i           (busy_o),
    .operation_i      (operation_i),
    .value_i          (value_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .out_valid_i      (out_valid_o),
    .product_i        (product_o),
    .row_index_i      (row_index_o),
    .column_index_i   (column_index_o),
    .column_last_i    (column_last_o),
    .matrix_done_i    (matrix_done_o),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_count)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int unsigned dim_of(input logic [DIM_W-1:0] raw);
    int unsigned r;
    if (raw == '0) begin
      r = 1;
    end else if (raw > DIM_W'(MAX_ROWS)) begin
      r = MAX_ROWS;
    end else begin
      r = raw;
    end
    return r;
  endfunction

  // B items may only read store entries that have been loaded since reset.
  function automatic bit store_ready();
    int unsigned span;
    span = dim_of(rows_raw) * dim_of(inner_raw);
    for (int unsigned k = 0; k < span; k++) begin
      if (!a_written[k]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    logic [DATA_W-1:0] v;
    case ($urandom_range(0, 7))
      0: v = '0;
      1: v = '1;
      default: v = DATA_W'($urandom);
    endcase
    return v;
  endfunction

  task automatic send_item(input logic op, input logic [DATA_W-1:0] val);
    int unsigned span;
    if (op == OP_LOAD_A) begin
      span = dim_of(rows_raw) * dim_of(inner_raw);
      if (load_ptr >= span) load_ptr = 0;
      a_written[load_ptr] = 1'b1;
      load_ptr++;
      if (load_ptr >= span) load_ptr = 0;
    end
    start_i     <= 1'b1;
    operation_i <= op;
    value_i     <= val;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic send_b(input logic [DATA_W-1:0] val);
    while (!store_ready()) send_item(OP_LOAD_A, pick_value());
    send_item(OP_LOAD_B, val);
  endtask

  task automatic pause(input int unsigned n);
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic settle();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending_count != 0 || busy_o);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CFG_DATA_W'(data);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_ROWS) begin
      rows_raw = DIM_W'(data);
    end else if (idx == REG_INNER) begin
      inner_raw = DIM_W'(data);
    end
    @(posedge clk_i);
  endtask

  task automatic run_random(input int unsigned r, input int unsigned i,
                            input int unsigned c, input int unsigned n);
    settle();
    write_reg(REG_ROWS, r);
    write_reg(REG_INNER, i);
    write_reg(REG_COLS, c);
    repeat (n) begin
      if (idling_on && $urandom_range(0, 3) == 0) pause($urandom_range(1, 19));
      if ($urandom_range(0, 12 * dim_of(inner_raw)) == 0) begin
        send_item(OP_LOAD_A, pick_value());
      end else begin
        send_b(pick_value());
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(OP_LOAD_A, 16'hFFFF);
    send_item(OP_LOAD_B, 16'hFFFF);
    send_item(OP_LOAD_B, 16'h0000);
    send_item(OP_LOAD_A, 16'h8000);
    send_item(OP_LOAD_B, 16'h0002);
    send_item(OP_LOAD_A, 16'h0001);
    send_item(OP_LOAD_B, 16'hFFFF);

    settle();
    write_reg(REG_ROWS, 0);
    write_reg(REG_INNER, 0);
    write_reg(REG_COLS, 0);
    write_reg(REG_UNUSED, 13'h1FFF);
    send_item(OP_LOAD_B, 16'h1234);

    settle();
    write_reg(REG_ROWS, 2);
    write_reg(REG_INNER, 2);
    write_reg(REG_COLS, 2);
    send_item(OP_LOAD_A, 16'hFFFF);
    send_item(OP_LOAD_A, 16'h0001);
    send_item(OP_LOAD_A, 16'hAAAA);
    send_item(OP_LOAD_A, 16'h5555);
    send_item(OP_LOAD_B, 16'hFFFF);
    send_item(OP_LOAD_B, 16'hFFFF);
    send_item(OP_LOAD_B, 16'h0000);
    send_item(OP_LOAD_B, 16'h0003);
    send_item(OP_LOAD_B, 16'h0001);
    send_item(OP_LOAD_A, 16'h0007);
    send_item(OP_LOAD_B, 16'h0001);
    send_item(OP_LOAD_B, 16'h0001);
    send_item(OP_LOAD_B, 16'h5555);

    settle();
    write_reg(REG_INNER, 1);
    send_item(OP_LOAD_B, 16'hAAAA);

    run_random(3, 4, 5, 24);
    run_random(16, 1, 2, 20);
    run_random(1, 16, 3, 18);
    run_random(31, 2, 1, 15);
    run_random(1, 1, 4096, 18);
    run_random(5, 20, 8191, 12);
    run_random(0, 3, 0, 10);
    idling_on = 1'b0;
    run_random(7, 3, 6, 20);

    settle();
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #4800000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
